### rtl/core/intel_hex_record_decoder_unit_defines.svh
// Assertion macros shared by the HEX decoder RTL
`ifndef INTEL_HEX_RECORD_DECODER_UNIT_DEFINES_SVH
`define INTEL_HEX_RECORD_DECODER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset
`define IHEX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define IHEX_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/core/ihex_pkg.sv
// Types, codes and helpers for the HEX record decoder
package ihex_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;

   // record types
   localparam logic [2:0] REC_DATA      = 3'd0;
   localparam logic [2:0] REC_EOF       = 3'd1;
   localparam logic [2:0] REC_SEGMENT   = 3'd2;
   localparam logic [2:0] REC_START_SEG = 3'd3;
   localparam logic [2:0] REC_EXT_LIN   = 3'd4;
   localparam logic [2:0] REC_START_LIN = 3'd5;

   // event kinds
   localparam logic [1:0] EV_DATA  = 2'd0;
   localparam logic [1:0] EV_EOF   = 2'd1;
   localparam logic [1:0] EV_ENTRY = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_BAD_DIGIT = 2'd0;
   localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
   localparam logic [1:0] ERR_SEGMENT   = 2'd2;
   localparam logic [1:0] ERR_CHECKSUM  = 2'd3;

   typedef logic [7:0]  char_type;
   typedef logic [1:0]  kind_type;
   typedef logic [31:0] word_type;
   typedef logic [1:0]  code_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_HEADER,
      PH_DATA,
      PH_CHECK
   } phase_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] res;
      res = 5'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         diff = c - CHAR_0;
         res  = {1'b1, diff[3:0]};
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         diff = c - CHAR_LA;
         res  = {1'b1, diff[3:0] + 4'd10};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         diff = c - CHAR_UA;
         res  = {1'b1, diff[3:0] + 4'd10};
      end
      return res;
   endfunction

endpackage

### rtl/core/ihex_req_if.sv
// Request channel: one text character per request
interface ihex_req_if;
   import ihex_pkg::*;

   logic     valid;
   logic     ready;
   char_type text_char;

   modport source (output valid, output text_char, input ready);
   modport sink   (input valid, input text_char, output ready);
endinterface

### rtl/core/ihex_rsp_if.sv
// Response channel: decoded events, at most one event per request
interface ihex_rsp_if;
   import ihex_pkg::*;

   logic     valid;
   logic     ready;
   kind_type event_kind;
   word_type payload;
   word_type byte_address;
   logic     run_start;
   code_type error_code;

   modport source (output valid, output event_kind, output payload, output byte_address,
                   output run_start, output error_code, input ready);
   modport sink   (input valid, input event_kind, input payload, input byte_address,
                   input run_start, input error_code, output ready);
endinterface

### rtl/core/intel_hex_record_decoder_unit.sv
// HEX record decoder: takes one character per cycle, unless the response side stalls,
// and reports data bytes, entry addresses, end of file and errors. Each accepted
// character is held in an input register, is decoded in a single pass that updates
// the parser state, and any event it produces is held in the response register.
// One request is taken every cycle as long as the response side keeps up; the only
// limit is the one decode pass per character. Nothing needs clearing after reset.
// After an end-of-file record all input is swallowed until reset.
module intel_hex_record_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   ihex_req_if.sink   req_chan,
   ihex_rsp_if.source rsp_chan
);
   import ihex_pkg::*;
   `include "intel_hex_record_decoder_unit_defines.svh"

   logic      in_valid_ff;
   char_type  in_char_ff;
   logic      check_enable_ff;

   phase_type phase_ff, phase_in;
   logic [8:0]  nibble_count_ff, nibble_count_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [15:0] record_offset_ff, record_offset_in;
   logic [2:0]  record_kind_ff, record_kind_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] value_ff, value_in;
   logic [15:0] upper_ff, upper_in;
   logic [31:0] expected_ff, expected_in;
   logic        run_open_ff, run_open_in;
   logic        file_done_ff, file_done_in;

   logic      rsp_valid_ff;
   kind_type  rsp_kind_ff, rsp_kind_in;
   word_type  rsp_payload_ff, rsp_payload_in;
   word_type  rsp_address_ff, rsp_address_in;
   logic      rsp_run_ff, rsp_run_in;
   code_type  rsp_code_ff, rsp_code_in;
   logic      emit;

   logic        out_free;
   logic        advance;
   logic        req_ready;
   logic [4:0]  decoded;
   logic [3:0]  nib;
   logic [7:0]  byte_val;
   logic [7:0]  idx;
   logic [8:0]  nc_inc;
   logic [31:0] addr;
   logic        do_finish;
   logic        do_begin;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_chan.ready = req_ready;

   assign decoded  = hex_decode(in_char_ff);
   assign nib      = decoded[3:0];
   assign byte_val = {high_nibble_ff, nib};
   assign idx      = nibble_count_ff[8:1];
   assign nc_inc   = nibble_count_ff + 9'd1;
   assign addr     = {upper_ff, record_offset_ff} + {24'd0, idx};

   always_comb begin
      phase_in         = phase_ff;
      nibble_count_in  = nibble_count_ff;
      high_nibble_in   = high_nibble_ff;
      record_length_in = record_length_ff;
      record_offset_in = record_offset_ff;
      record_kind_in   = record_kind_ff;
      sum_in           = sum_ff;
      value_in         = value_ff;
      upper_in         = upper_ff;
      expected_in      = expected_ff;
      run_open_in      = run_open_ff;
      file_done_in     = file_done_ff;
      emit             = 1'b0;
      rsp_kind_in      = EV_DATA;
      rsp_payload_in   = '0;
      rsp_address_in   = '0;
      rsp_run_in       = 1'b0;
      rsp_code_in      = ERR_BAD_DIGIT;
      do_finish        = 1'b0;
      do_begin         = 1'b0;

      if (file_done_ff) begin
         // frozen until reset
      end else if (phase_ff == PH_WAIT) begin
         do_begin = (in_char_ff == CHAR_COLON);
      end else if (phase_ff == PH_CHECK && !check_enable_ff) begin
         // checksum digits skipped undecoded
         if (nibble_count_ff != 9'd0) begin
            do_finish = 1'b1;
         end else begin
            nibble_count_in = nc_inc;
         end
      end else if (!decoded[4]) begin
         phase_in    = PH_WAIT;
         do_begin    = (in_char_ff == CHAR_COLON);
         emit        = 1'b1;
         rsp_kind_in = EV_ERROR;
         rsp_code_in = ERR_BAD_DIGIT;
      end else begin
         if (phase_ff == PH_DATA) begin
            value_in = {value_ff[27:0], nib};
         end
         if (!nibble_count_ff[0]) begin
            high_nibble_in  = nib;
            nibble_count_in = nc_inc;
         end else begin
            sum_in          = sum_ff + byte_val;
            nibble_count_in = nc_inc;
            unique case (phase_ff)
               PH_HEADER: begin
                  case (idx)
                     8'd0: record_length_in = byte_val;
                     8'd1: record_offset_in = {byte_val, 8'd0};
                     8'd2: record_offset_in = {record_offset_ff[15:8], byte_val};
                     default: begin
                        if (byte_val > {5'd0, REC_START_LIN}) begin
                           phase_in    = PH_WAIT;
                           emit        = 1'b1;
                           rsp_kind_in = EV_ERROR;
                           rsp_code_in = ERR_BAD_TYPE;
                        end else if (byte_val == {5'd0, REC_SEGMENT}) begin
                           phase_in    = PH_WAIT;
                           emit        = 1'b1;
                           rsp_kind_in = EV_ERROR;
                           rsp_code_in = ERR_SEGMENT;
                        end else begin
                           record_kind_in  = byte_val[2:0];
                           nibble_count_in = 9'd0;
                           phase_in = (record_length_ff != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                     end
                  endcase
               end
               PH_DATA: begin
                  if (record_kind_ff == REC_DATA) begin
                     emit           = 1'b1;
                     rsp_kind_in    = EV_DATA;
                     rsp_payload_in = {24'd0, byte_val};
                     rsp_address_in = addr;
                     rsp_run_in     = !run_open_ff || (addr != expected_ff);
                     expected_in    = addr + 32'd1;
                     run_open_in    = 1'b1;
                  end
                  if (nc_inc >= {record_length_ff, 1'b0}) begin
                     nibble_count_in = 9'd0;
                     phase_in        = PH_CHECK;
                  end
               end
               PH_CHECK: do_finish = 1'b1;
               PH_WAIT:  ;
            endcase
         end
      end

      if (do_finish) begin
         phase_in        = PH_WAIT;
         nibble_count_in = 9'd0;
         if (check_enable_ff && sum_in != 8'd0) begin
            emit        = 1'b1;
            rsp_kind_in = EV_ERROR;
            rsp_code_in = ERR_CHECKSUM;
         end else begin
            case (record_kind_ff) inside
               REC_EOF: begin
                  file_done_in = 1'b1;
                  emit         = 1'b1;
                  rsp_kind_in  = EV_EOF;
               end
               REC_START_SEG, REC_START_LIN: begin
                  emit           = 1'b1;
                  rsp_kind_in    = EV_ENTRY;
                  rsp_payload_in = value_in;
               end
               REC_EXT_LIN: upper_in = value_in[15:0];
               default: ;
            endcase
         end
      end

      if (do_begin) begin
         phase_in         = PH_HEADER;
         nibble_count_in  = 9'd0;
         high_nibble_in   = 4'd0;
         record_length_in = 8'd0;
         record_offset_in = 16'd0;
         record_kind_in   = REC_DATA;
         sum_in           = 8'd0;
         value_in         = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_chan.valid && req_ready) begin
         in_char_ff <= req_chan.text_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         check_enable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_WAIT;
         nibble_count_ff  <= 9'd0;
         high_nibble_ff   <= 4'd0;
         record_length_ff <= 8'd0;
         record_offset_ff <= 16'd0;
         record_kind_ff   <= REC_DATA;
         sum_ff           <= 8'd0;
         value_ff         <= 32'd0;
         upper_ff         <= 16'd0;
         expected_ff      <= 32'd0;
         run_open_ff      <= 1'b0;
         file_done_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         nibble_count_ff  <= nibble_count_in;
         high_nibble_ff   <= high_nibble_in;
         record_length_ff <= record_length_in;
         record_offset_ff <= record_offset_in;
         record_kind_ff   <= record_kind_in;
         sum_ff           <= sum_in;
         value_ff         <= value_in;
         upper_ff         <= upper_in;
         expected_ff      <= expected_in;
         run_open_ff      <= run_open_in;
         file_done_ff     <= file_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff && emit;
      end
      if (advance && emit) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_address_ff <= rsp_address_in;
         rsp_run_ff     <= rsp_run_in;
         rsp_code_ff    <= rsp_code_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_kind   = rsp_kind_ff;
   assign rsp_chan.payload      = rsp_payload_ff;
   assign rsp_chan.byte_address = rsp_address_ff;
   assign rsp_chan.run_start    = rsp_run_ff;
   assign rsp_chan.error_code   = rsp_code_ff;

   `IHEX_ASSERT(a_eof_sticky, file_done_ff |=> file_done_ff, "end of file flag dropped")
   `IHEX_ASSERT(a_silent_after_eof, (file_done_ff && advance) |-> !emit, "event after end of file")
   `IHEX_ASSERT(a_stall_blocks, (in_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_ready, "request taken while stalled")
   `IHEX_ASSERT(a_data_has_length, (phase_ff == PH_DATA) |-> (record_length_ff != 8'd0), "data phase with empty record")
   `IHEX_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_valid_ff && !in_valid_ff), "pipeline not empty after reset")
endmodule
